FILE: rtl/core/spq_pkg.sv
// Types and codes shared by the priority queue front end and back end.
`default_nettype none

package spq_pkg;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 4;
    localparam int OCC_W  = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_with_cancel_unit.sv
// Sorted priority queue with cancel: top level joining the front end and back end.
// Usage:
//   Slave channel (i_s_*): one beat is one operation. tuser carries the kind
//   (insert, pop, cancel; the fourth code does nothing), tdata the identifier
//   and the priority. Master channel (o_m_*): every operation yields exactly one
//   result beat with status, identifier, priority and the occupancy afterward.
//   Entries leave in descending priority; equal priorities leave in arrival order.
//   A beat accepted into an empty command buffer is written into the buffer and
//   then into the result register before it shows on o_m_tvalid. Throughput: one
//   operation per cycle while the receiver takes results, set by the slot array,
//   which compares and shifts all DEPTH slots in parallel.
//   A two-entry command buffer sits between the input decoder and the slot array,
//   and a result register holds the outgoing beat. When the receiver stalls, the
//   result is held, the slot array stops, and the buffer fills; o_s_tready drops
//   once it holds two commands.
//   Reset (synchronous, active low) empties the queue and both buffers; the slot
//   contents are not cleared, since only occupied slots are ever read.
`default_nettype none

module sorted_priority_queue_with_cancel_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // entry_id [7:0], entry_priority [11:8]
    input  wire logic [1:0]  i_s_tuser,   // kind [1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // status [1:0], out_id [9:2], out_priority [13:10],
                                          // occupancy [17:14]
);

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    spq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    spq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/spq_front.sv
// Front end: accepts input beats, decodes the operation and buffers commands.
`default_nettype none

module spq_front
    import spq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // entry_id [7:0], entry_priority [11:8]
    input  wire logic [1:0]  i_s_tuser,   // kind [1:0]
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       in_cmd;

    always_comb begin
        in_cmd.op   = t_op'(i_s_tuser);
        in_cmd.id   = i_s_tdata[ID_W-1:0];
        in_cmd.prio = i_s_tdata[ID_W+PRIO_W-1:ID_W];
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = o_cmd_valid && i_cmd_take;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spq_back.sv
// Back end: sorted slot array with insert, pop and cancel, and the result register.
`default_nettype none

module spq_back
    import spq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_take,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata   // status [1:0], out_id [9:2], out_priority [13:10],
                                         // occupancy [17:14]
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [ID_W-1:0]   r_ids   [DEPTH];
    logic [PRIO_W-1:0] r_prios [DEPTH];
    logic [CW-1:0]     r_count;

    logic [ID_W-1:0]   n_ids   [DEPTH];
    logic [PRIO_W-1:0] n_prios [DEPTH];
    logic [CW-1:0]     n_count;

    logic              r_out_valid;
    t_status           r_status;
    logic [ID_W-1:0]   r_res_id;
    logic [PRIO_W-1:0] r_res_prio;
    logic [OCC_W-1:0]  r_occ;

    t_status           n_status;
    logic [ID_W-1:0]   n_res_id;
    logic [PRIO_W-1:0] n_res_prio;
    logic [CW+OCC_W-1:0] occ_ext;

    logic [DEPTH-1:0]  live;
    logic [DEPTH-1:0]  ge;
    logic [DEPTH-1:0]  prev_ge;
    logic [DEPTH-1:0]  match;
    logic [DEPTH-1:0]  first;
    logic [DEPTH-1:0]  from_hit;
    logic              found;
    logic              fire;

    assign fire       = i_cmd_valid && (!r_out_valid || i_m_tready);
    assign o_cmd_take = fire;

    // Per-slot compares; each cell checks itself and its neighbor, and a running chain marks the first match onward.
    always_comb begin
        logic run;
        run = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            live[i] = (CW'(i) < r_count);
            ge[i]   = live[i] && (r_prios[i] >= i_cmd.prio);
            if (i_cmd.op == OP_CANCEL) begin
                match[i] = live[i] && (r_ids[i] == i_cmd.id);
            end else begin
                match[i] = live[i] && (i == 0);
            end
            first[i]    = match[i] && !run;
            run         = run || match[i];
            from_hit[i] = run;
        end
        found      = run;
        prev_ge[0] = 1'b1;
        for (int i = 1; i < DEPTH; i++) begin
            prev_ge[i] = ge[i-1];
        end
    end

    always_comb begin
        logic [ID_W-1:0]   sel_id;
        logic [PRIO_W-1:0] sel_prio;
        sel_id   = '0;
        sel_prio = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_id   = sel_id | (r_ids[i] & {ID_W{first[i]}});
            sel_prio = sel_prio | (r_prios[i] & {PRIO_W{first[i]}});
        end

        n_ids      = r_ids;
        n_prios    = r_prios;
        n_count    = r_count;
        n_status   = ST_OK;
        n_res_id   = '0;
        n_res_prio = '0;

        unique case (i_cmd.op)
            OP_INSERT: begin
                if (r_count == CW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    // The new entry lands right after the last slot of equal or higher
                    // priority; every lower slot moves one place toward the back.
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!ge[i] && prev_ge[i]) begin
                            n_ids[i]   = i_cmd.id;
                            n_prios[i] = i_cmd.prio;
                        end
                    end
                    for (int i = 1; i < DEPTH; i++) begin
                        if (!ge[i] && !prev_ge[i]) begin
                            n_ids[i]   = r_ids[i-1];
                            n_prios[i] = r_prios[i-1];
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP, OP_CANCEL: begin
                if (found) begin
                    n_res_id   = sel_id;
                    n_res_prio = sel_prio;
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (from_hit[i]) begin
                            n_ids[i]   = r_ids[i+1];
                            n_prios[i] = r_prios[i+1];
                        end
                    end
                    n_count = r_count - 1'b1;
                end else if (i_cmd.op == OP_POP) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase

        occ_ext = {{OCC_W{1'b0}}, n_count};
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ids      <= n_ids;
            r_prios    <= n_prios;
            r_status   <= n_status;
            r_res_id   <= n_res_id;
            r_res_prio <= n_res_prio;
            r_occ      <= occ_ext[OCC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_occ, r_res_prio, r_res_id, r_status};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cmd.op == OP_INSERT) && (r_count != CW'(DEPTH))
        |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted insert did not grow the queue");

    a_cancel_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cmd.op == OP_CANCEL) && found
        |=> r_count == $past(r_count) - 1'b1)
        else $error("successful cancel did not shrink the queue");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cmd.op == OP_POP) && (r_count == '0)
        |=> r_out_valid && (r_status == ST_EMPTY))
        else $error("pop on empty queue did not report empty");
`endif

endmodule

`default_nettype wire
